// ===== rtl/core/prd_pkg.sv =====
package prd_pkg;

    // Queue geometry; QUEUE_DEPTH must be a power of two (pointers wrap naturally)
    localparam int QUEUE_DEPTH = 64;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Field and register widths
    localparam int TAG_W      = 16;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int LIM_W      = 7;
    localparam int WIN_W      = 16;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LIMIT_CAP  = 64;

    // Reset values of the configuration registers
    localparam logic [LIM_W-1:0] LIMIT_NORMAL_RST = LIM_W'(20);
    localparam logic [LIM_W-1:0] LIMIT_PRIV_RST   = LIM_W'(64);
    localparam logic [WIN_W-1:0] WINDOW_RST       = WIN_W'(300);

    // Command buffer between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ENQ_NORMAL = 2'd0,
        OP_ENQ_FORCED = 2'd1,
        OP_TICK       = 2'd2,
        OP_SET_PRIV   = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        RES_SENT    = 2'd0,
        RES_QUEUED  = 2'd1,
        RES_DROPPED = 2'd2
    } res_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_NORMAL = 2'd0,
        CFG_LIMIT_PRIV   = 2'd1,
        CFG_WINDOW       = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_ENQUEUE,
        CMD_TICK,
        CMD_PRIV
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TIMER,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } disp_state_t;

    // Classified request handed from front to back
    typedef struct packed {
        cmd_kind_t         kind;
        logic              forced;
        logic [TAG_W-1:0]  tag;
        logic              priv;
    } cmd_t;

    // Configuration register set
    typedef struct packed {
        logic [LIM_W-1:0] limit_normal;
        logic [LIM_W-1:0] limit_privileged;
        logic [WIN_W-1:0] window_ticks;
    } cfg_t;

endpackage

// ===== rtl/core/prd_in_if.sv =====
interface prd_in_if import prd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TAG_W-1:0]  command_tag;
    logic              privileged;

    modport source (output valid, output operation, output command_tag,
                    output privileged, input ready);
    modport sink   (input valid, input operation, input command_tag,
                    input privileged, output ready);
endinterface

// ===== rtl/core/prd_out_if.sv =====
interface prd_out_if import prd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag_out;
    logic              from_forced;
    logic              last;

    modport source (output valid, output kind, output tag_out, output from_forced,
                    output last, input ready);
    modport sink   (input valid, input kind, input tag_out, input from_forced,
                    input last, output ready);
endinterface

// ===== rtl/core/priority_rate_limited_dispatcher.sv =====
// Channel   Dir  Handshake       Payload
// request   in   valid/ready     operation, command_tag, privileged
// result    out  valid/ready     kind, tag_out, from_forced, last
// cfg       in   cfg_we          cfg_index, cfg_data (write only)
//
// A request enters a four-entry command buffer; the back end then takes an
// enqueue or a privilege update directly from its idle state, and works a tick
// as a timer step, then a store read and an output load per tag sent, bounded
// by the single read port of each tag store.
// Reset clears queue pointers, send count, window timer and the privileged
// flag; the tag stores need no clearing. A stalled result holds the back end
// while the front keeps buffering requests.
module priority_rate_limited_dispatcher import prd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    prd_in_if.sink                request,
    prd_out_if.source             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIMIT_NORMAL:
                begin
                    cfg_next.limit_normal = cfg_data[LIM_W-1:0];
                end
                CFG_LIMIT_PRIV:
                begin
                    cfg_next.limit_privileged = cfg_data[LIM_W-1:0];
                end
                CFG_WINDOW:
                begin
                    cfg_next.window_ticks = cfg_data[WIN_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_normal     <= LIMIT_NORMAL_RST;
            cfg_reg.limit_privileged <= LIMIT_PRIV_RST;
            cfg_reg.window_ticks     <= WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    prd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .result    (result)
    );

endmodule

// ===== rtl/core/prd_front.sv =====
module prd_front import prd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    prd_in_if.sink    request,
    output logic      cmd_valid,
    output cmd_t      cmd,
    input  logic      cmd_pop
);

    cmd_t               buf_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg;
    logic [CMDQ_CW-1:0] count_next;
    logic               push;
    logic               pop;
    cmd_t               classified;

    // Decode the operation into a command
    always_comb
    begin
        classified.kind   = CMD_TICK;
        classified.forced = 1'b0;
        classified.tag    = request.command_tag;
        classified.priv   = request.privileged;
        case (op_t'(request.operation))
            OP_ENQ_NORMAL:
            begin
                classified.kind = CMD_ENQUEUE;
            end
            OP_ENQ_FORCED:
            begin
                classified.kind   = CMD_ENQUEUE;
                classified.forced = 1'b1;
            end
            OP_TICK:
            begin
                classified.kind = CMD_TICK;
            end
            OP_SET_PRIV:
            begin
                classified.kind = CMD_PRIV;
            end
            default:
            begin
                classified.kind = CMD_TICK;
            end
        endcase
    end

    // Accept while the command buffer has room
    assign request.ready = (count_reg != CMDQ_CW'(CMDQ_DEPTH));
    assign push          = request.valid & request.ready;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_pop & cmd_valid;
    assign cmd           = buf_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CMDQ_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== rtl/core/prd_back.sv =====
module prd_back import prd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    prd_out_if.source result
);

    // Tag stores, undefined until written
    logic [TAG_W-1:0] forced_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0] normal_mem [QUEUE_DEPTH];

    disp_state_t       state_reg,   state_next;
    logic [QA_W-1:0]   f_head_reg,  f_head_next;
    logic [FILL_W-1:0] f_fill_reg,  f_fill_next;
    logic [QA_W-1:0]   n_head_reg,  n_head_next;
    logic [FILL_W-1:0] n_fill_reg,  n_fill_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [WIN_W-1:0]  elapsed_reg, elapsed_next;
    logic              priv_reg,    priv_next;
    logic              pick_forced_reg, pick_forced_next;
    logic              last_reg,    last_next;

    logic              out_valid_reg, out_valid_next;
    res_kind_t         out_kind_reg,  out_kind_next;
    logic [TAG_W-1:0]  out_tag_reg,   out_tag_next;
    logic              out_forced_reg, out_forced_next;
    logic              out_last_reg,  out_last_next;
    logic              out_load;
    logic              out_free;

    logic              f_wr_en, n_wr_en;
    logic              f_rd_en, n_rd_en;
    logic [QA_W-1:0]   f_tail, n_tail;
    logic [TAG_W-1:0]  f_rd_reg, n_rd_reg;

    logic [LIM_W-1:0]  lim_raw;
    logic [LIM_W-1:0]  lim_clamped;
    logic [CNT_W-1:0]  stop;
    logic [WIN_W-1:0]  elapsed_inc;
    logic [CNT_W:0]    count_plus;
    logic              can_send;

    // Active limit, clamped to one through the cap, less one
    always_comb
    begin
        lim_raw = priv_reg ? cfg.limit_privileged : cfg.limit_normal;
        if (lim_raw == '0)
        begin
            lim_clamped = LIM_W'(1);
        end
        else if (lim_raw > LIM_W'(LIMIT_CAP))
        begin
            lim_clamped = LIM_W'(LIMIT_CAP);
        end
        else
        begin
            lim_clamped = lim_raw;
        end
        stop = CNT_W'(lim_clamped - LIM_W'(1));
    end

    assign f_tail      = f_head_reg + f_fill_reg[QA_W-1:0];
    assign n_tail      = n_head_reg + n_fill_reg[QA_W-1:0];
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + WIN_W'(1);
    assign count_plus  = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign can_send    = (count_reg < stop);
    assign out_free    = !out_valid_reg || result.ready;

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        f_head_next      = f_head_reg;
        f_fill_next      = f_fill_reg;
        n_head_next      = n_head_reg;
        n_fill_next      = n_fill_reg;
        count_next       = count_reg;
        elapsed_next     = elapsed_reg;
        priv_next        = priv_reg;
        pick_forced_next = pick_forced_reg;
        last_next        = last_reg;
        out_load         = 1'b0;
        out_kind_next    = out_kind_reg;
        out_tag_next     = out_tag_reg;
        out_forced_next  = out_forced_reg;
        out_last_next    = out_last_reg;
        f_wr_en          = 1'b0;
        n_wr_en          = 1'b0;
        f_rd_en          = 1'b0;
        n_rd_en          = 1'b0;
        cmd_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_ENQUEUE:
                        begin
                            // Store the tag or report a drop
                            if (out_free)
                            begin
                                cmd_pop         = 1'b1;
                                out_load        = 1'b1;
                                out_tag_next    = cmd.tag;
                                out_forced_next = cmd.forced;
                                out_last_next   = 1'b1;
                                out_kind_next   = RES_QUEUED;
                                if (cmd.forced)
                                begin
                                    if (f_fill_reg == FILL_W'(QUEUE_DEPTH))
                                    begin
                                        out_kind_next = RES_DROPPED;
                                    end
                                    else
                                    begin
                                        f_wr_en     = 1'b1;
                                        f_fill_next = f_fill_reg + FILL_W'(1);
                                    end
                                end
                                else
                                begin
                                    if (n_fill_reg == FILL_W'(QUEUE_DEPTH))
                                    begin
                                        out_kind_next = RES_DROPPED;
                                    end
                                    else
                                    begin
                                        n_wr_en     = 1'b1;
                                        n_fill_next = n_fill_reg + FILL_W'(1);
                                    end
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            cmd_pop    = 1'b1;
                            state_next = ST_TIMER;
                        end
                        CMD_PRIV:
                        begin
                            cmd_pop   = 1'b1;
                            priv_next = cmd.priv;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_TIMER:
            begin
                // Advance the window while the send count is nonzero; close it once its length has passed
                if (count_reg != '0)
                begin
                    if (elapsed_inc >= cfg.window_ticks)
                    begin
                        count_next   = '0;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                state_next = ST_DRAIN_RD;
            end
            ST_DRAIN_RD:
            begin
                // Pop forced first, then normal, while under the limit
                if (can_send && (f_fill_reg != '0 || n_fill_reg != '0))
                begin
                    if (f_fill_reg != '0)
                    begin
                        f_rd_en          = 1'b1;
                        f_head_next      = f_head_reg + QA_W'(1);
                        f_fill_next      = f_fill_reg - FILL_W'(1);
                        pick_forced_next = 1'b1;
                    end
                    else
                    begin
                        n_rd_en          = 1'b1;
                        n_head_next      = n_head_reg + QA_W'(1);
                        n_fill_next      = n_fill_reg - FILL_W'(1);
                        pick_forced_next = 1'b0;
                    end
                    if (count_reg == '0)
                    begin
                        elapsed_next = '0;
                    end
                    count_next = (count_reg == '1) ? count_reg : count_plus[CNT_W-1:0];
                    last_next  = !((count_plus < {1'b0, stop}) &&
                                   (f_fill_next != '0 || n_fill_next != '0));
                    state_next = ST_DRAIN_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_OUT:
            begin
                // Hand the popped tag to the output register
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = RES_SENT;
                    out_tag_next    = pick_forced_reg ? f_rd_reg : n_rd_reg;
                    out_forced_next = pick_forced_reg;
                    out_last_next   = last_reg;
                    state_next      = last_reg ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            f_head_reg    <= '0;
            f_fill_reg    <= '0;
            n_head_reg    <= '0;
            n_fill_reg    <= '0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            priv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            f_head_reg    <= f_head_next;
            f_fill_reg    <= f_fill_next;
            n_head_reg    <= n_head_next;
            n_fill_reg    <= n_fill_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            priv_reg      <= priv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pick_forced_reg <= pick_forced_next;
        last_reg        <= last_next;
        out_kind_reg    <= out_kind_next;
        out_tag_reg     <= out_tag_next;
        out_forced_reg  <= out_forced_next;
        out_last_reg    <= out_last_next;
    end

    // Forced tag store
    always_ff @(posedge clk)
    begin
        if (f_wr_en)
        begin
            forced_mem[f_tail] <= cmd.tag;
        end
        if (f_rd_en)
        begin
            f_rd_reg <= forced_mem[f_head_reg];
        end
    end

    // Normal tag store
    always_ff @(posedge clk)
    begin
        if (n_wr_en)
        begin
            normal_mem[n_tail] <= cmd.tag;
        end
        if (n_rd_en)
        begin
            n_rd_reg <= normal_mem[n_head_reg];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.tag_out     = out_tag_reg;
    assign result.from_forced = out_forced_reg;
    assign result.last        = out_last_reg;

endmodule

// ===== tb/tb_priority_rate_limited_dispatcher.sv =====
module tb_priority_rate_limited_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_OFF      = 300;

    typedef struct packed {
        res_kind_t        kind;
        logic [TAG_W-1:0] tag;
        logic             forced;
        logic             last;
    } dispatch_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    prd_in_if  request_if ();
    prd_out_if result_if ();

    priority_rate_limited_dispatcher u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Dispatcher state as the predictor sees it
    logic [TAG_W-1:0] forced_tags[$];
    logic [TAG_W-1:0] normal_tags[$];
    int unsigned      sends_in_window = 0;
    int unsigned      window_age      = 0;
    logic             priv_mode       = 1'b0;
    logic [LIM_W-1:0] lim_normal      = LIMIT_NORMAL_RST;
    logic [LIM_W-1:0] lim_priv        = LIMIT_PRIV_RST;
    logic [WIN_W-1:0] window_len      = WINDOW_RST;

    dispatch_t   expected_results[$];
    int          error_count  = 0;
    bit          idle_on      = 1'b1;
    int          hold_cycles  = 0;
    int unsigned cycle_count  = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive result ready: long hold-off on request, random stalls while idling is on
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_if.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                result_if.ready <= !(idle_on && $urandom_range(99) < 13);
        end
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        dispatch_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d tag %h forced %0d last %0d",
                       result_if.kind, result_if.tag_out, result_if.from_forced,
                       result_if.last);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_if.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, result_if.kind);
                    error_count++;
                end
                if (result_if.tag_out !== want.tag)
                begin
                    $error("tag_out: expected %h, actual %h", want.tag, result_if.tag_out);
                    error_count++;
                end
                if (result_if.from_forced !== want.forced)
                begin
                    $error("from_forced: expected %0d, actual %0d", want.forced,
                           result_if.from_forced);
                    error_count++;
                end
                if (result_if.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, result_if.last);
                    error_count++;
                end
            end
        end
    end

    // Limit in force, clamped to 1..64
    function automatic int unsigned active_limit();
        int unsigned lim;
        lim = priv_mode ? lim_priv : lim_normal;
        if (lim < 1)
            lim = 1;
        if (lim > LIMIT_CAP)
            lim = LIMIT_CAP;
        return lim;
    endfunction

    // Send tags from one queue until it empties or the window budget is used
    function automatic void drain_tags(bit from_forced);
        int unsigned stop_at;
        dispatch_t   r;
        stop_at = active_limit() - 1;
        while (sends_in_window < stop_at &&
               (from_forced ? forced_tags.size() : normal_tags.size()) > 0)
        begin
            r.kind   = RES_SENT;
            r.forced = from_forced;
            r.last   = 1'b0;
            if (from_forced)
                r.tag = forced_tags.pop_front();
            else
                r.tag = normal_tags.pop_front();
            if (sends_in_window == 0)
                window_age = 0;
            sends_in_window++;
            expected_results.push_back(r);
        end
    endfunction

    // Advance the predicted state by one request and queue its results
    function automatic void predict_dispatch(op_t op, logic [TAG_W-1:0] tag, logic priv);
        dispatch_t r;
        int        n_before;
        case (op)
            OP_ENQ_NORMAL, OP_ENQ_FORCED:
            begin
                r.kind   = RES_QUEUED;
                r.tag    = tag;
                r.forced = (op == OP_ENQ_FORCED);
                r.last   = 1'b1;
                if (op == OP_ENQ_FORCED && forced_tags.size() < QUEUE_DEPTH)
                    forced_tags.push_back(tag);
                else if (op == OP_ENQ_NORMAL && normal_tags.size() < QUEUE_DEPTH)
                    normal_tags.push_back(tag);
                else
                    r.kind = RES_DROPPED;
                expected_results.push_back(r);
            end
            OP_SET_PRIV:
                priv_mode = priv;
            default:
            begin
                n_before = expected_results.size();
                // Window timer runs only while something was sent
                if (sends_in_window != 0)
                begin
                    if (window_age < 65535)
                        window_age++;
                    if (window_age >= window_len)
                    begin
                        sends_in_window = 0;
                        window_age      = 0;
                    end
                end
                drain_tags(1'b1);
                drain_tags(1'b0);
                if (expected_results.size() > n_before)
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // Offer one request; returns at the falling edge after it was taken
    task automatic send_request(op_t op, logic [TAG_W-1:0] tag, logic priv);
        while (idle_on && $urandom_range(99) < 13)
        begin
            request_if.valid <= 1'b0;
            @(negedge clk);
        end
        request_if.valid       <= 1'b1;
        request_if.operation   <= op;
        request_if.command_tag <= tag;
        request_if.privileged  <= priv;
        @(posedge clk);
        while (!request_if.ready)
            @(posedge clk);
        predict_dispatch(op, tag, priv);
        @(negedge clk);
    endtask

    // Stop offering and wait for every pending result plus drain time
    task automatic wait_quiet();
        request_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three registers while the block is idle
    task automatic set_limits(logic [CFG_DATA_W-1:0] ln, logic [CFG_DATA_W-1:0] lp,
                              logic [CFG_DATA_W-1:0] win);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LIMIT_NORMAL;
        cfg_data  <= ln;
        @(negedge clk);
        cfg_index <= CFG_LIMIT_PRIV;
        cfg_data  <= lp;
        @(negedge clk);
        cfg_index <= CFG_WINDOW;
        cfg_data  <= win;
        @(negedge clk);
        cfg_we     <= 1'b0;
        lim_normal = ln[LIM_W-1:0];
        lim_priv   = lp[LIM_W-1:0];
        window_len = win[WIN_W-1:0];
    endtask

    // Mostly enqueues and ticks with random tags, some privilege changes
    task automatic random_burst(int count);
        int               r;
        op_t              op;
        logic [TAG_W-1:0] tag;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                op = OP_ENQ_NORMAL;
            else if (r < 60)
                op = OP_ENQ_FORCED;
            else if (r < 90)
                op = OP_TICK;
            else
                op = OP_SET_PRIV;
            case ($urandom_range(9))
                0:       tag = '0;
                1:       tag = '1;
                default: tag = TAG_W'($urandom);
            endcase
            send_request(op, tag, 1'($urandom_range(1)));
        end
    endtask

    // Extremes of the fields and every operation at reset settings
    task automatic test_basic_commands();
        send_request(OP_TICK, 16'h0000, 1'b0);
        send_request(OP_SET_PRIV, 16'hFFFF, 1'b1);
        send_request(OP_SET_PRIV, 16'h0000, 1'b0);
        send_request(OP_ENQ_NORMAL, 16'h0000, 1'b0);
        send_request(OP_ENQ_NORMAL, 16'hFFFF, 1'b1);
        send_request(OP_ENQ_FORCED, 16'hFFFF, 1'b0);
        send_request(OP_ENQ_FORCED, 16'h0000, 1'b1);
        send_request(OP_ENQ_FORCED, 16'h5A5A, 1'b0);
        send_request(OP_ENQ_NORMAL, 16'hA5A5, 1'b0);
        send_request(OP_TICK, 16'hFFFF, 1'b1);
        send_request(OP_ENQ_NORMAL, 16'h1234, 1'b0);
        send_request(OP_SET_PRIV, 16'h0000, 1'b1);
        send_request(OP_TICK, 16'h0000, 1'b0);
        send_request(OP_TICK, 16'h0000, 1'b0);
        send_request(OP_SET_PRIV, 16'h0000, 1'b0);
    endtask

    // Fill both queues past full with sends blocked, then drain in full ticks
    task automatic test_queue_full();
        set_limits(16'd0, 16'd0, 16'd1);
        send_request(OP_SET_PRIV, 16'h0000, 1'b0);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_request(OP_ENQ_FORCED, TAG_W'($urandom), 1'b0);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
            send_request(OP_ENQ_NORMAL, TAG_W'($urandom), 1'b0);
        send_request(OP_TICK, 16'h0000, 1'b0);
        set_limits(16'd127, 16'd64, 16'd1);
        repeat (3) send_request(OP_TICK, 16'h0000, 1'b0);
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_result_backpressure();
        set_limits(16'd20, 16'd64, 16'd300);
        hold_cycles = HOLD_OFF;
        for (int i = 0; i < 20; i++)
            send_request($urandom_range(1) ? OP_ENQ_FORCED : OP_ENQ_NORMAL,
                         TAG_W'($urandom), 1'b0);
        send_request(OP_TICK, 16'h0000, 1'b0);
    endtask

    // Random traffic over several register settings
    task automatic test_random_traffic();
        set_limits(16'd20, 16'd64, 16'd300);
        random_burst(7);
        set_limits(16'd1, 16'd64, 16'd0);
        random_burst(7);
        set_limits(16'd64, 16'd1, 16'd3);
        random_burst(7);
        set_limits(16'd127, 16'd127, 16'd1);
        random_burst(7);
        set_limits(16'd5, 16'd9, 16'd65535);
        random_burst(7);
        // no idling on either side for this stretch
        set_limits(CFG_DATA_W'($urandom_range(64, 1)), CFG_DATA_W'($urandom_range(64, 1)),
                   CFG_DATA_W'($urandom_range(20, 1)));
        idle_on = 1'b0;
        random_burst(7);
        wait_quiet();
        idle_on = 1'b1;
    endtask

    initial
    begin
        request_if.valid       <= 1'b0;
        request_if.operation   <= OP_TICK;
        request_if.command_tag <= '0;
        request_if.privileged  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_LIMIT_NORMAL;
        cfg_data               <= '0;
        rst_n                  <= 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basic_commands();
        test_queue_full();
        test_result_backpressure();
        test_random_traffic();

        wait_quiet();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
